// ===== rtl/core/cbts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit timing search package
// Shared types, codes and limits of the bit timing search block.
// ----------------------------------------------------------------------------
package cbts_pkg;

    // Search limits.
    localparam logic [6:0] PRESCALE_MAX    = 7'd64;
    localparam logic [4:0] QUANTA_MIN      = 5'd8;
    localparam logic [4:0] QUANTA_MAX      = 5'd25;
    localparam logic [3:0] PHASE_MAX       = 4'd8;
    localparam logic [3:0] PHASE_MIN       = 4'd2;
    localparam logic [7:0] PROPAGATION_MAX = 8'd8;
    // Phase one above this value no longer drags phase two along with it.
    localparam logic [3:0] PHASE_TRACK_MAX = 4'd5;
    // Quanta used by sync plus both minimum phase segments.
    localparam logic [4:0] MIN_OVERHEAD    = 5'd5;

    // Search status codes.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SEARCH = 2'd1;
    localparam logic [1:0] PH_FOUND  = 2'd2;
    localparam logic [1:0] PH_FAILED = 2'd3;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PRESCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PROPAGATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE_TWO   = 3'd4;

    typedef struct packed {
        logic op;
        logic rx_ok;
        logic mob_error;
        logic timer_overflow;
        logic general_error;
    } cbts_in_t;

    typedef struct packed {
        logic [1:0] search_status;
        logic       apply_timing;
        logic [6:0] prescale;
        logic [7:0] propagation;
        logic [3:0] phase_one;
        logic [3:0] phase_two;
        logic [2:0] jump_width;
        logic [7:0] timeout_prescale;
    } cbts_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
    } cbts_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_advance;
        logic hit;
        logic exhaust;
    } cbts_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/cbts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit timing search controller
// Sequences acceptance, the candidate walk and the result handoff.
// ----------------------------------------------------------------------------
module cbts_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cbts_pkg::cbts_cmd_t     cmd,
    input  wire cbts_pkg::cbts_sts_t sts
);
    import cbts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.need_advance ? ST_STEP : ST_DONE;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (sts.hit || sts.exhaust) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // One transaction at a time: after an accept the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("cbts_ctrl: input accepted while an item is in flight");

    // A result is only loaded when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("cbts_ctrl: result overwritten before it was taken");

    // A waiting result stays valid until the receiver takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("cbts_ctrl: result dropped before it was taken");

endmodule
`default_nettype wire

// ===== rtl/core/cbts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit timing search datapath
// Holds the search state and evaluates one timing candidate per cycle.
// ----------------------------------------------------------------------------
module cbts_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [cbts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire cbts_pkg::cbts_in_t           s_item,
    output cbts_pkg::cbts_out_t               m_item,
    input  wire cbts_pkg::cbts_cmd_t          cmd,
    output cbts_pkg::cbts_sts_t               sts
);
    import cbts_pkg::*;

    // Configuration.
    logic       mode_reg;
    logic [6:0] start_pre_reg;
    logic [3:0] start_prop_reg, start_p1_reg, start_p2_reg;

    // Search state.
    logic [1:0]  phase_reg, phase_next;
    logic [6:0]  pre_reg, pre_next;
    logic [7:0]  prop_reg, prop_next;
    logic [3:0]  p1_reg, p1_next;
    logic [3:0]  p2_reg, p2_next;
    logic [4:0]  q_reg, q_next;
    logic        skip_reg, skip_next;
    logic        rp_reg, rp_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] att_reg, att_next;
    logic        apply_reg, apply_next;
    cbts_out_t   out_reg;

    // Candidate evaluation.
    logic [3:0] p1_inc, p1_c, p2_c;
    logic       wrap;
    logic [7:0] prop_c;
    logic [6:0] tot_c, p2x4, p2x3;
    logic       prop_ok;
    logic [15:0] att_sat;

    // Start clamps.
    logic [6:0] cl_pre;
    logic [3:0] cl_prop, cl_p1, cl_p2;
    logic [4:0] cl_sum;

    always_comb begin
        p1_inc = skip_reg ? p1_reg : p1_reg + 4'd1;
        wrap   = (p1_inc > PHASE_MAX) && (p2_reg >= PHASE_MAX);
        if (p1_inc > PHASE_TRACK_MAX) begin
            if ({1'b0, p1_inc} > ({1'b0, p2_reg} + 5'd1)) begin
                p2_c = p2_reg + 4'd1;
                p1_c = p2_reg + 4'd1;
            end else begin
                p2_c = p2_reg;
                p1_c = p1_inc;
            end
        end else begin
            p2_c = p1_inc;
            p1_c = p1_inc;
        end
        prop_c  = {3'b000, q_reg} - ({4'h0, p1_c} + {4'h0, p2_c} + 8'd1);
        prop_ok = (prop_c >= 8'd1) && (prop_c <= PROPAGATION_MAX);
        tot_c   = 7'd1 + {3'b000, prop_c[3:0]} + {3'b000, p1_c};
        p2x4    = {1'b0, p2_c, 2'b00};
        p2x3    = {3'b000, p2_c} + {2'b00, p2_c, 1'b0};
    end

    assign sts.hit     = !wrap && prop_ok && (p2x4 >= tot_c) && (p2x3 <= tot_c);
    assign sts.exhaust = wrap && (q_reg >= QUANTA_MAX) && (pre_reg >= PRESCALE_MAX);
    assign sts.need_advance = (s_item.op == OP_START) ? mode_reg :
        ((phase_reg == PH_SEARCH) && !s_item.rx_ok &&
         (s_item.mob_error || s_item.general_error || (s_item.timer_overflow && ovf_reg)));

    assign att_sat = (att_reg == 16'hFFFF) ? att_reg : att_reg + 16'd1;

    always_comb begin
        cl_pre  = (start_pre_reg < 7'd1) ? 7'd1 :
                  (start_pre_reg > PRESCALE_MAX) ? PRESCALE_MAX : start_pre_reg;
        cl_prop = (start_prop_reg < 4'd1) ? 4'd1 :
                  ({4'h0, start_prop_reg} > PROPAGATION_MAX) ? PROPAGATION_MAX[3:0] :
                  start_prop_reg;
        cl_p1   = (start_p1_reg < PHASE_MIN) ? PHASE_MIN :
                  (start_p1_reg > PHASE_MAX) ? PHASE_MAX : start_p1_reg;
        cl_p2   = (start_p2_reg < PHASE_MIN) ? PHASE_MIN :
                  (start_p2_reg > PHASE_MAX) ? PHASE_MAX : start_p2_reg;
        cl_sum  = {1'b0, cl_prop} + {1'b0, cl_p1} + {1'b0, cl_p2} + 5'd1;
    end

    always_comb begin
        phase_next = phase_reg;
        pre_next   = pre_reg;
        prop_next  = prop_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        q_next     = q_reg;
        skip_next  = skip_reg;
        rp_next    = rp_reg;
        ovf_next   = ovf_reg;
        att_next   = att_reg;
        apply_next = apply_reg;

        if (cmd.accept) begin
            apply_next = 1'b0;
            if (s_item.op == OP_START) begin
                phase_next = PH_SEARCH;
                ovf_next   = 1'b0;
                if (!mode_reg) begin
                    pre_next   = 7'd1;
                    q_next     = QUANTA_MIN;
                    p1_next    = PHASE_MIN;
                    p2_next    = PHASE_MIN;
                    prop_next  = {3'b000, QUANTA_MIN - MIN_OVERHEAD};
                    skip_next  = 1'b1;
                    rp_next    = 1'b1;
                    // Applied straight away from a cleared attempt count.
                    att_next   = 16'd1;
                    apply_next = 1'b1;
                end else begin
                    pre_next  = cl_pre;
                    prop_next = {4'h0, cl_prop};
                    p1_next   = cl_p1;
                    p2_next   = cl_p2;
                    q_next    = (cl_sum > QUANTA_MIN) ? cl_sum : QUANTA_MIN;
                    skip_next = 1'b0;
                    rp_next   = 1'b0;
                    att_next  = 16'd0;
                end
            end else if (phase_reg == PH_SEARCH) begin
                if (s_item.rx_ok) begin
                    phase_next = PH_FOUND;
                end else begin
                    if (s_item.timer_overflow) begin
                        ovf_next = 1'b1;
                    end
                    if (s_item.general_error) begin
                        rp_next = 1'b1;
                    end
                end
            end
        end else if (cmd.step) begin
            skip_next = 1'b0;
            if (wrap) begin
                p1_next   = PHASE_MIN;
                p2_next   = PHASE_MIN;
                skip_next = 1'b1;
                if (q_reg < QUANTA_MAX) begin
                    q_next = q_reg + 5'd1;
                end else begin
                    q_next = QUANTA_MIN;
                    if (pre_reg < PRESCALE_MAX) begin
                        pre_next = pre_reg + 7'd1;
                    end else begin
                        phase_next = PH_FAILED;
                    end
                end
            end else begin
                p1_next   = p1_c;
                p2_next   = p2_c;
                prop_next = prop_c;
                if (sts.hit && rp_reg) begin
                    att_next   = att_sat;
                    ovf_next   = 1'b0;
                    apply_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            start_pre_reg  <= 7'd1;
            start_prop_reg <= 4'd1;
            start_p1_reg   <= 4'd2;
            start_p2_reg   <= 4'd2;
            phase_reg      <= PH_IDLE;
            pre_reg        <= 7'd1;
            prop_reg       <= 8'd0;
            p1_reg         <= PHASE_MIN;
            p2_reg         <= PHASE_MIN;
            q_reg          <= QUANTA_MIN;
            skip_reg       <= 1'b0;
            rp_reg         <= 1'b0;
            ovf_reg        <= 1'b0;
            att_reg        <= 16'd0;
            apply_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SEARCH_MODE:       mode_reg       <= cfg_wdata[0];
                    CFG_START_PRESCALE:    start_pre_reg  <= cfg_wdata;
                    CFG_START_PROPAGATION: start_prop_reg <= cfg_wdata[3:0];
                    CFG_START_PHASE_ONE:   start_p1_reg   <= cfg_wdata[3:0];
                    CFG_START_PHASE_TWO:   start_p2_reg   <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            phase_reg <= phase_next;
            pre_reg   <= pre_next;
            prop_reg  <= prop_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            q_reg     <= q_next;
            skip_reg  <= skip_next;
            rp_reg    <= rp_next;
            ovf_reg   <= ovf_next;
            att_reg   <= att_next;
            apply_reg <= apply_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.search_status    <= phase_reg;
            out_reg.apply_timing     <= apply_reg;
            out_reg.prescale         <= pre_reg;
            out_reg.propagation      <= prop_reg;
            out_reg.phase_one        <= p1_reg;
            out_reg.phase_two        <= p2_reg;
            out_reg.jump_width       <= p2_reg[3:1];
            out_reg.timeout_prescale <= att_reg[10:3];
        end
    end

    assign m_item = out_reg;

    // A step can not both land on a candidate and run out of candidates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !(sts.hit && sts.exhaust))
        else $error("cbts_dp: candidate hit and exhaustion at once");

    // A reported reprogram always follows at least one counted attempt.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && apply_reg |=> (m_item.apply_timing && att_reg != 16'd0))
        else $error("cbts_dp: apply reported without an attempt");

    // Found is only reached from an active search.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FOUND) && ($past(phase_reg) != PH_FOUND)
            |-> ($past(phase_reg) == PH_SEARCH))
        else $error("cbts_dp: found entered outside a search");

    // Phase two never leaves its legal range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_reg >= PHASE_MIN) && (p2_reg <= PHASE_MAX))
        else $error("cbts_dp: phase two out of range");

endmodule
`default_nettype wire

// ===== rtl/core/can_bit_timing_search_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit timing search
// Listens on the bus and walks candidate bit timings until a frame is seen.
//
// Input channel (s_valid/s_ready/s_item): a start transaction begins a search,
// a poll transaction carries the receive and error flags of the listening
// message object. Every input transaction yields exactly one result
// transaction on m_valid/m_ready/m_item with the status, the apply flag and
// the current timing segments.
// An item that moves the search walks the candidate timings until one fits or
// none is left. The candidate evaluator examines one phase/quanta/prescale
// combination per cycle, ten phase pairs and one wrap step per quanta total.
// The longest run without an acceptable candidate covers the quanta totals
// above 20 and the step to the next prescaler.
// One item is processed at a time; s_ready is high only between items.
// If the receiver stalls, the result waits in the output register. One more
// item is still accepted and processed, its result is held until the output
// register is free, and any further item is held off until then.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, and the block itself does not enforce this.
// Reset (aresetn low, synchronous) returns the search to idle with the
// minimum timing and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module can_bit_timing_search_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [cbts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire cbts_pkg::cbts_in_t              s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output cbts_pkg::cbts_out_t                  m_item
);
    import cbts_pkg::*;

    cbts_cmd_t cmd;
    cbts_sts_t sts;

    cbts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    cbts_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .m_item    (m_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

// ===== sim/cbts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search checker
// Watches the configuration port and both channels of the search block. It
// keeps its own copy of the registers and of the search state, and predicts
// one result for every input transaction. Each result is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module cbts_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [cbts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire cbts_pkg::cbts_in_t              s_item,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire cbts_pkg::cbts_out_t             m_item,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   found_count,
    output int                                   failed_count
);
    import cbts_pkg::*;

    // Register copies.
    logic       mode_q;
    logic [6:0] start_psc;
    logic [3:0] start_prop;
    logic [3:0] start_ph1;
    logic [3:0] start_ph2;

    // Search state.
    logic [1:0]  srch_phase;
    logic [6:0]  psc;
    logic [7:0]  prop;
    logic [3:0]  ph1;
    logic [3:0]  ph2;
    logic [4:0]  quanta;
    logic        hold_step;
    logic        reprog;
    logic        ovf_seen;
    logic [15:0] attempts;

    cbts_out_t expected_timing[$];
    cbts_out_t want;
    int        results_seen;

    initial begin
        fail_count   = 0;
        pending      = 0;
        found_count  = 0;
        failed_count = 0;
        results_seen = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        fail_count++;
    endtask

    function automatic int clamp_to(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void count_attempt();
        if (attempts != 16'hFFFF) attempts = attempts + 16'd1;
        ovf_seen = 1'b0;
    endfunction

    // Walks to the next candidate whose propagation is in range and whose
    // sample point lies between 75 and 80 percent. Returns 0 when exhausted.
    function automatic bit step_candidate();
        int diff;
        int seg_sum;
        while (1'b1) begin
            if (!hold_step) ph1 = ph1 + 4'd1;
            hold_step = 1'b0;
            if (ph1 > PHASE_MAX && ph2 >= PHASE_MAX) begin
                ph1       = PHASE_MIN;
                ph2       = PHASE_MIN;
                hold_step = 1'b1;
                if (quanta < QUANTA_MAX) begin
                    quanta = quanta + 5'd1;
                end else begin
                    quanta = QUANTA_MIN;
                    if (psc < PRESCALE_MAX) psc = psc + 7'd1;
                    else return 1'b0;
                end
            end else begin
                if (ph1 > PHASE_TRACK_MAX) begin
                    if (int'(ph1) > int'(ph2) + 1) begin
                        ph2 = ph2 + 4'd1;
                        ph1 = ph2;
                    end
                end else begin
                    ph2 = ph1;
                end
                diff = int'(quanta) - int'(ph1) - int'(ph2) - 1;
                prop = diff[7:0];
                if (prop >= 8'd1 && prop <= PROPAGATION_MAX) begin
                    seg_sum = 1 + int'(prop) + int'(ph1);
                    if (4 * int'(ph2) >= seg_sum && 3 * int'(ph2) <= seg_sum) return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic bit move_to_next();
        if (!step_candidate()) begin
            srch_phase = PH_FAILED;
            failed_count++;
            return 1'b0;
        end
        if (reprog) begin
            count_attempt();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic cbts_out_t predict_search_step(input cbts_in_t it);
        cbts_out_t r;
        bit        applied;
        bit        move;
        int        sum;
        applied = 1'b0;
        if (it.op == OP_START) begin
            attempts   = 16'd0;
            ovf_seen   = 1'b0;
            srch_phase = PH_SEARCH;
            if (mode_q == 1'b0) begin
                psc       = 7'd1;
                quanta    = QUANTA_MIN;
                ph1       = PHASE_MIN;
                ph2       = PHASE_MIN;
                prop      = {3'd0, QUANTA_MIN - MIN_OVERHEAD};
                hold_step = 1'b1;
                reprog    = 1'b1;
                count_attempt();
                applied   = 1'b1;
            end else begin
                psc  = 7'(clamp_to(int'(start_psc), 1, int'(PRESCALE_MAX)));
                prop = 8'(clamp_to(int'(start_prop), 1, int'(PROPAGATION_MAX)));
                ph1  = 4'(clamp_to(int'(start_ph1), int'(PHASE_MIN), int'(PHASE_MAX)));
                ph2  = 4'(clamp_to(int'(start_ph2), int'(PHASE_MIN), int'(PHASE_MAX)));
                sum  = int'(prop) + int'(ph1) + int'(ph2) + 1;
                quanta    = (sum > int'(QUANTA_MIN)) ? sum[4:0] : QUANTA_MIN;
                hold_step = 1'b0;
                reprog    = 1'b0;
                applied   = move_to_next();
            end
        end else if (srch_phase == PH_SEARCH) begin
            if (it.rx_ok) begin
                srch_phase = PH_FOUND;
                found_count++;
            end else begin
                move = it.mob_error;
                // The first overflow after an apply is only remembered.
                if (it.timer_overflow) begin
                    if (!ovf_seen) ovf_seen = 1'b1;
                    else move = 1'b1;
                end
                if (it.general_error) begin
                    move   = 1'b1;
                    reprog = 1'b1;
                end
                if (move) applied = move_to_next();
            end
        end
        r.search_status    = srch_phase;
        r.apply_timing     = applied;
        r.prescale         = psc;
        r.propagation      = prop;
        r.phase_one        = ph1;
        r.phase_two        = ph2;
        r.jump_width       = ph2[3:1];
        r.timeout_prescale = attempts[10:3];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q     = 1'b0;
            start_psc  = 7'd1;
            start_prop = 4'd1;
            start_ph1  = 4'd2;
            start_ph2  = 4'd2;
            srch_phase = PH_IDLE;
            psc        = 7'd1;
            prop       = 8'd0;
            ph1        = PHASE_MIN;
            ph2        = PHASE_MIN;
            quanta     = QUANTA_MIN;
            hold_step  = 1'b0;
            reprog     = 1'b0;
            ovf_seen   = 1'b0;
            attempts   = 16'd0;
            expected_timing.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SEARCH_MODE:       mode_q     = cfg_wdata[0];
                    CFG_START_PRESCALE:    start_psc  = cfg_wdata[6:0];
                    CFG_START_PROPAGATION: start_prop = cfg_wdata[3:0];
                    CFG_START_PHASE_ONE:   start_ph1  = cfg_wdata[3:0];
                    CFG_START_PHASE_TWO:   start_ph2  = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            // Results are taken before new predictions: the block processes one
            // transaction at a time, so a result never belongs to this edge's input.
            if (m_valid && m_ready) begin
                if (expected_timing.size() == 0) begin
                    report("result transaction with nothing expected");
                end else begin
                    want = expected_timing.pop_front();
                    if (m_item.search_status !== want.search_status)
                        report($sformatf("search_status expected %0d got %0d",
                                         want.search_status, m_item.search_status));
                    if (m_item.apply_timing !== want.apply_timing)
                        report($sformatf("apply_timing expected %0d got %0d",
                                         want.apply_timing, m_item.apply_timing));
                    if (m_item.prescale !== want.prescale)
                        report($sformatf("prescale expected %0d got %0d",
                                         want.prescale, m_item.prescale));
                    if (m_item.propagation !== want.propagation)
                        report($sformatf("propagation expected %0d got %0d",
                                         want.propagation, m_item.propagation));
                    if (m_item.phase_one !== want.phase_one)
                        report($sformatf("phase_one expected %0d got %0d",
                                         want.phase_one, m_item.phase_one));
                    if (m_item.phase_two !== want.phase_two)
                        report($sformatf("phase_two expected %0d got %0d",
                                         want.phase_two, m_item.phase_two));
                    if (m_item.jump_width !== want.jump_width)
                        report($sformatf("jump_width expected %0d got %0d",
                                         want.jump_width, m_item.jump_width));
                    if (m_item.timeout_prescale !== want.timeout_prescale)
                        report($sformatf("timeout_prescale expected %0d got %0d",
                                         want.timeout_prescale, m_item.timeout_prescale));
                end
                results_seen++;
            end
            if (s_valid && s_ready) expected_timing.push_back(predict_search_step(s_item));
        end
        pending = expected_timing.size();
    end

endmodule

// ===== sim/tb_can_bit_timing_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search testbench
// Drives directed and random search sessions into the block, each session a
// register setting followed by a start and a run of status polls, with bursty
// input traffic and a stalling receiver. A checker beside the block predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_can_bit_timing_search_top;
    import cbts_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1100;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    cbts_in_t              s_item;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    cbts_out_t             m_item;

    int fail_count;
    int pending;
    int found_count;
    int failed_count;

    int cycle_count  = 0;
    int burst_left   = 0;
    int starts_sent  = 0;
    int polls_sent   = 0;
    int settings_used = 0;
    int stall_left   = 0;
    int stall_style  = 0;
    int style_cycles = 0;

    can_bit_timing_search_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    cbts_checker timing_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .fail_count   (fail_count),
        .pending      (pending),
        .found_count  (found_count),
        .failed_count (failed_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: the stall style switches at random among always ready, short
    // random stalls and long stalls.
    always @(negedge aclk) begin
        if (style_cycles == 0) begin
            stall_style  = $urandom_range(0, 2);
            style_cycles = $urandom_range(100, 600);
        end else begin
            style_cycles--;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_style == 1 && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else if (stall_style == 2 && $urandom_range(0, 1) == 0) begin
            stall_left = $urandom_range(0, 19);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("tb_can_bit_timing_search_top: FAIL");
        $finish;
    end

    function automatic cbts_in_t make_item(input logic op, input logic rx, input logic merr,
                                           input logic ovf, input logic gerr);
        cbts_in_t it;
        it.op             = op;
        it.rx_ok          = rx;
        it.mob_error      = merr;
        it.timer_overflow = ovf;
        it.general_error  = gerr;
        return it;
    endfunction

    // Mostly polls with error flags that keep the search moving; a received
    // frame is rare so that searches run long. Now and then a random item.
    function automatic cbts_in_t random_poll();
        if ($urandom_range(0, 19) == 0) return cbts_in_t'(5'($urandom_range(0, 31)));
        return make_item(OP_POLL, $urandom_range(0, 99) < 3, $urandom_range(0, 99) < 30,
                         $urandom_range(0, 99) < 45, $urandom_range(0, 99) < 20);
    endfunction

    function automatic int pick_segment();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 15;
            2: return 8;
            3: return 1;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input cbts_in_t item);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        if (item.op == OP_START) starts_sent++;
        else polls_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic load_settings(input logic mode, input int psc, input int prop,
                                 input int ph1, input int ph2);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEARCH_MODE;
        cfg_wdata <= {6'd0, mode};
        @(negedge aclk);
        cfg_index <= CFG_START_PRESCALE;
        cfg_wdata <= psc[6:0];
        @(negedge aclk);
        cfg_index <= CFG_START_PROPAGATION;
        cfg_wdata <= prop[6:0];
        @(negedge aclk);
        cfg_index <= CFG_START_PHASE_ONE;
        cfg_wdata <= ph1[6:0];
        @(negedge aclk);
        cfg_index <= CFG_START_PHASE_TWO;
        cfg_wdata <= ph2[6:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int   n_polls;
        int   psc;
        logic mode;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default registers: search from the minimum timing.
        send_item(make_item(OP_POLL, 1'b1, 1'b1, 1'b1, 1'b1));   // poll while idle changes nothing
        send_item(make_item(OP_START, 1'b1, 1'b1, 1'b1, 1'b1));  // flags on a start are ignored
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b0));   // first overflow is only noted
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b0));   // second overflow moves on
        send_item(make_item(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_START, 1'b0, 1'b0, 1'b0, 1'b0));  // restart while searching
        send_item(make_item(OP_POLL, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_POLL, 1'b1, 1'b1, 1'b0, 1'b0));   // frame seen wins over errors
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1));   // nothing moves once found
        drain_results();

        // Start registers above range clamp to the last candidate: fails at once.
        load_settings(1'b1, 127, 15, 15, 15);
        send_item(make_item(OP_START, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_POLL, 1'b0, 1'b1, 1'b1, 1'b1));
        drain_results();

        // Start registers below range clamp to the minimum; nothing is applied
        // until a general error asks for reprogramming.
        load_settings(1'b1, 0, 0, 0, 0);
        send_item(make_item(OP_START, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b0));
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b0));
        send_item(make_item(OP_POLL, 1'b0, 1'b0, 1'b1, 1'b1));

        // Random sessions: new registers, a start, then a run of polls. Starts
        // near the top prescaler let searches run out of candidates.
        while (starts_sent + polls_sent < ITEM_TARGET) begin
            drain_results();
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: psc = 0;
                1: psc = 127;
                2: psc = 64;
                3: psc = 1;
                4, 5, 6: psc = $urandom_range(58, 64);
                default: psc = $urandom_range(1, 64);
            endcase
            load_settings(mode, psc, pick_segment(), pick_segment(), pick_segment());
            send_item(make_item(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            n_polls = $urandom_range(3, 70);
            repeat (n_polls) send_item(random_poll());
        end

        drain_results();
        repeat (50) @(negedge aclk);
        $display("Ran %0d starts and %0d polls under %0d register settings.",
                 starts_sent, polls_sent, settings_used);
        $display("Searches found a timing %0d times and ran out of candidates %0d times.",
                 found_count, failed_count);
        if (pending != 0) $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_can_bit_timing_search_top: PASS");
        end else begin
            $display("tb_can_bit_timing_search_top: FAIL");
        end
        $finish;
    end

endmodule
